FILE: hw/rtl/scfr_pkg.sv
// Shared types and constants for the serial command frame receiver.
// No dependencies; the top level and scfr_ctrl import this package.
`default_nettype none

package scfr_pkg;

  localparam int RIDX_W = 6;
  localparam int WPOS_W = 8;
  localparam int TICK_W = 16;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [7:0] START_BYTE     = 8'hFF;
  localparam logic [7:0] ACT_SET_COLORS = 8'hA0;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACTION = 4'b0010,
    PH_LENGTH = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } frame_res_t;

  typedef struct packed {
    logic              en;
    logic [WPOS_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scfr_if.sv
// Valid/ready channel interfaces for the frame receiver's input and result beats.
// Depends on nothing but plain logic types.
`default_nettype none

interface scfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  logic [5:0] read_index;

  modport source (output valid, mode, rx_byte, read_index, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface scfr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, result_kind, status, read_data, input ready);
  modport sink   (input valid, result_kind, status, read_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/serial_command_frame_receiver_top.sv
// Top level of the serial command frame receiver: config register, color store
// RAM with per-entry valid bits, and two-stage result path. Uses scfr_pkg,
// scfr_if, scfr_ram and scfr_ctrl.
//
//   Channel   Dir  Payload                              Handshake
//   in_ch     in   mode, rx_byte, read_index            valid/ready
//   out_ch    out  result_kind, status, read_data       valid/ready
//   cfg_*     in   cfg_wdata (timeout_ticks)            cfg_we, no wait
//
// One item per cycle is accepted while in_ch is ready; its state update
// completes in the accept cycle. A result passes through the read stage, beside
// the RAM read register, and then the output register on its way to out_ch.
// Reset is synchronous and needs no clearing pass: a valid bit per store entry
// makes unwritten entries read as zero. The input stalls only when both the read
// stage and the output register hold a result and out_ch is not ready.
`default_nettype none

module serial_command_frame_receiver_top
  import scfr_pkg::*;
#(
  parameter int STORE_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  scfr_in_if.sink                in_ch,
  scfr_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata
);

  // Reads reach only the first 64 bytes, so entries past that are never observed.
  localparam int MEM_DEPTH = (STORE_BYTES < 64) ? STORE_BYTES : 64;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  logic [TICK_W-1:0]    timeout_r;
  logic                 accept;
  logic                 rd_en;
  logic                 rd_in_range;
  logic                 wr_in_range;
  logic [MEM_AW-1:0]    rd_addr;
  logic [MEM_AW-1:0]    wr_addr;
  logic [7:0]           ram_rdata;
  logic [MEM_DEPTH-1:0] vld_r;
  frame_res_t           res;
  store_wr_t            wr;

  logic    s1_v_r, s1_v_nxt;
  logic    s1_kind_r;
  status_t s1_status_r;
  logic    s1_hit_r;
  logic    s1_adv;

  logic       out_v_r, out_v_nxt;
  logic       out_kind_r;
  status_t    out_status_r;
  logic [7:0] out_data_r;

  assign in_ch.ready = !s1_v_r || !out_v_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_en       = accept && (in_ch.mode == MODE_READ);
  assign rd_in_range = {1'b0, in_ch.read_index} < 7'(MEM_DEPTH);
  assign rd_addr     = MEM_AW'(in_ch.read_index);
  assign wr_in_range = {1'b0, wr.addr} < 9'(MEM_DEPTH);
  assign wr_addr     = MEM_AW'(wr.addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  scfr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .mode          (in_ch.mode),
    .rx_byte       (in_ch.rx_byte),
    .timeout_ticks (timeout_r),
    .res           (res),
    .wr            (wr)
  );

  scfr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en && wr_in_range),
    .waddr (wr_addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en && wr_in_range) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read stage: holds a result while the RAM output register carries its data.
  assign s1_adv = s1_v_r && (!out_v_r || out_ch.ready);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = res.valid || rd_en;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r   <= rd_en ? KIND_READ : KIND_STATUS;
      s1_status_r <= rd_en ? ST_SUCCESS : res.status;
      s1_hit_r    <= rd_en && rd_in_range && vld_r[rd_addr];
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r   <= s1_kind_r;
      out_status_r <= s1_status_r;
      out_data_r   <= s1_hit_r ? ram_rdata : 8'd0;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_data   = out_data_r;

  // A status beat never carries store data.
  a_status_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_kind_r == KIND_STATUS) |-> out_data_r == 8'd0)
    else $error("status beat with nonzero read_data");

  // Input stalls only when both result stages are occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r)
    else $error("input stalled with a free result stage");

  // Every read beat lands in the read stage on the next cycle.
  a_read_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_v_r && (s1_kind_r == KIND_READ))
    else $error("read beat lost before the read stage");

  // A write and a read never issue to the store in the same cycle.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && rd_en))
    else $error("store write and read in one cycle");

endmodule

`default_nettype wire

FILE: hw/rtl/scfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module scfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scfr_ctrl.sv
// Frame parser: phase, byte count, write position and tick count.
// Depends on scfr_pkg; issues store writes and status results.
`default_nettype none

module scfr_ctrl
  import scfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        mode,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [TICK_W-1:0] timeout_ticks,
  output frame_res_t             res,
  output store_wr_t              wr
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        remain_r, remain_nxt;
  logic [WPOS_W-1:0] wpos_r, wpos_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] elapsed_inc;
  logic [7:0]        remain_dec;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + TICK_W'(1);
  assign remain_dec  = remain_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    remain_nxt  = remain_r;
    wpos_nxt    = wpos_r;
    elapsed_nxt = elapsed_r;
    res.valid   = 1'b0;
    res.status  = ST_SUCCESS;
    wr.en       = 1'b0;
    wr.addr     = wpos_r;
    wr.data     = rx_byte;
    if (accept) begin
      unique case (mode)
        MODE_TICK: begin
          if (phase_r != PH_IDLE) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_ticks) begin
              res.valid  = 1'b1;
              res.status = ST_TIMEOUT;
              phase_nxt  = PH_IDLE;
            end
          end
        end
        MODE_BYTE: begin
          unique case (phase_r)
            PH_IDLE: begin
              if (rx_byte == START_BYTE) begin
                phase_nxt   = PH_ACTION;
                elapsed_nxt = '0;
              end
            end
            PH_ACTION: begin
              if (rx_byte == ACT_SET_COLORS) begin
                phase_nxt   = PH_LENGTH;
                elapsed_nxt = '0;
              end else begin
                res.valid  = 1'b1;
                res.status = ST_UNKNOWN;
                phase_nxt  = PH_IDLE;
              end
            end
            PH_LENGTH: begin
              if (rx_byte == 8'd0) begin
                res.valid = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                remain_nxt  = rx_byte;
                wpos_nxt    = '0;
                elapsed_nxt = '0;
                phase_nxt   = PH_DATA;
              end
            end
            PH_DATA: begin
              // The top level drops the write when the position is past the store.
              wr.en      = 1'b1;
              wpos_nxt   = wpos_r + WPOS_W'(1);
              remain_nxt = remain_dec;
              if (remain_dec == 8'd0) begin
                res.valid = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      remain_r  <= '0;
      wpos_r    <= '0;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      remain_r  <= remain_nxt;
      wpos_r    <= wpos_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

`default_nettype wire
